### rtl/half_duplex_uart_with_fifos_defines.svh
// ----------------------------------------------------------------------------
// Half-duplex UART assertion macros
// Shared property wrappers, sampled on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef HALF_DUPLEX_UART_WITH_FIFOS_DEFINES_SVH
`define HALF_DUPLEX_UART_WITH_FIFOS_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define HDU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hduart: same-cycle property failed");

// Consequent checked in the cycle after the antecedent.
`define HDU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hduart: next-cycle property failed");

`endif

### rtl/hduart_pkg.sv
// ----------------------------------------------------------------------------
// Half-duplex UART package
// Constants, codes, shared types and helper functions of the serial port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hduart_pkg;

  localparam int FifoDepth = 64;
  localparam int AddrW     = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CntW      = $clog2(FifoDepth + 1);
  localparam int CfgW      = 16;
  localparam int CfgIdxW   = 2;
  localparam int TickW     = 17;

  typedef enum logic [1:0] {
    OpTick = 2'd0,
    OpPush = 2'd1,
    OpPop  = 2'd2,
    OpNop  = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDataBits    = 2'd0,
    CfgParityEn    = 2'd1,
    CfgOddParity   = 2'd2,
    CfgTicksPerBit = 2'd3
  } cfg_e;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic tx_line;
    logic rts_line;
    logic rx_valid;
    logic tx_busy;
    logic rx_busy;
    logic tx_full;
    logic frame_error;
    logic parity_error;
  } status_t;

  function automatic logic [AddrW-1:0] ptr_inc(input logic [AddrW-1:0] p);
    logic [AddrW-1:0] r;
    if (p == AddrW'(FifoDepth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // Parity over the data bits only; bit 7 is ignored in 7-bit mode.
  function automatic logic parity_of(input logic [7:0] v, input logic n7, input logic odd);
    logic [7:0] m;
    m = n7 ? {1'b0, v[6:0]} : v;
    return (^m) ^ odd;
  endfunction

endpackage

`default_nettype wire

### rtl/hduart_ram.sv
// ----------------------------------------------------------------------------
// Half-duplex UART FIFO RAM
// Simple dual-port memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hduart_ram #(
  parameter int Depth = 64,
  parameter int Width = 8
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output      logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/hduart_core.sv
// ----------------------------------------------------------------------------
// Half-duplex UART control core
// Holds configuration, FIFO pointers and framing state; steps the latter two
// once per accepted word and issues the FIFO RAM reads and writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hduart_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_en_i,
  input  wire logic [1:0]                    op_i,
  input  wire logic [7:0]                    tx_byte_i,
  input  wire logic                          rx_pin_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [hduart_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [hduart_pkg::CfgW-1:0]   cfg_wdata_i,
  output      hduart_pkg::ram_req_t          tx_ram_o,
  output      hduart_pkg::ram_req_t          rx_ram_o,
  input  wire logic [7:0]                    tx_rdata_i,
  output      hduart_pkg::status_t           status_o
);

  import hduart_pkg::*;

  logic [3:0]       data_bits_q;
  logic             par_en_q, odd_q;
  logic [15:0]      tpb_q;

  logic [AddrW-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [CntW-1:0]  tx_cnt_q, tx_cnt_d;
  logic [AddrW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [CntW-1:0]  rx_cnt_q, rx_cnt_d;

  logic [7:0]       tx_shift_q, tx_shift_d;
  logic [3:0]       tx_bits_q, tx_bits_d;
  logic [1:0]       tx_extra_q, tx_extra_d;
  logic             par_val_q, par_val_d;
  logic             tx_pend_q, tx_pend_d;
  logic             tx_pn7_q, tx_pn7_d, tx_podd_q, tx_podd_d;
  logic             tx_fwd_q, tx_fwd_d;
  logic [7:0]       tx_fwd_byte_q, tx_fwd_byte_d;

  logic [7:0]       rx_shift_q, rx_shift_d;
  logic [3:0]       rx_bits_q, rx_bits_d;
  logic [1:0]       rx_extra_q, rx_extra_d;
  logic [TickW-1:0] tick_q, tick_d;

  logic             tx_prog_q, tx_prog_d, tx_treq_q, tx_treq_d;
  logic             rx_prog_q, rx_prog_d, armed_q, armed_d;
  logic             err_frame_q, err_frame_d, err_par_q, err_par_d;
  logic             line_tx_q, line_tx_d, rts_q, rts_d;
  logic             rx_valid_q, rx_valid_d;

  logic             n7;
  logic [3:0]       nb;
  logic [7:0]       tx_byte_eff, sh_cur, rx_byte;
  logic             pv_cur, fire, txb, arm;
  logic [3:0]       rbits;
  logic             tx_we, tx_re, rx_we, rx_re;

  assign n7          = (data_bits_q == 4'd7);
  assign nb          = n7 ? 4'd7 : 4'd8;
  assign tx_byte_eff = tx_fwd_q ? tx_fwd_byte_q : tx_rdata_i;
  assign sh_cur      = tx_pend_q ? tx_byte_eff : tx_shift_q;
  assign pv_cur      = tx_pend_q ? parity_of(tx_byte_eff, tx_pn7_q, tx_podd_q) : par_val_q;
  assign rx_byte     = n7 ? {1'b0, rx_shift_q[7:1]} : rx_shift_q;
  assign rbits       = (rx_bits_q != 4'd0) ? (rx_bits_q - 4'd1) : 4'd0;

  always_comb begin
    tx_head_d = tx_head_q;  tx_tail_d = tx_tail_q;  tx_cnt_d = tx_cnt_q;
    rx_head_d = rx_head_q;  rx_tail_d = rx_tail_q;  rx_cnt_d = rx_cnt_q;
    tx_shift_d = sh_cur;    par_val_d = pv_cur;     tx_pend_d = 1'b0;
    tx_bits_d = tx_bits_q;  tx_extra_d = tx_extra_q;
    tx_pn7_d = tx_pn7_q;    tx_podd_d = tx_podd_q;
    tx_fwd_d = tx_fwd_q;    tx_fwd_byte_d = tx_fwd_byte_q;
    rx_shift_d = rx_shift_q; rx_bits_d = rx_bits_q; rx_extra_d = rx_extra_q;
    tick_d = tick_q;
    tx_prog_d = tx_prog_q;  tx_treq_d = tx_treq_q;
    rx_prog_d = rx_prog_q;  armed_d = armed_q;
    err_frame_d = err_frame_q; err_par_d = err_par_q;
    line_tx_d = line_tx_q;  rts_d = rts_q;
    rx_valid_d = 1'b0;
    fire = 1'b0;  txb = 1'b0;  arm = 1'b0;
    tx_we = 1'b0; tx_re = 1'b0; rx_we = 1'b0; rx_re = 1'b0;

    case (op_i)
      OpTick: begin
        if (tx_prog_q || rx_prog_q) begin
          fire   = (tick_q <= TickW'(1));
          tick_d = fire ? {1'b0, tpb_q} : (tick_q - TickW'(1));
          if (fire && tx_prog_q) begin
            if (tx_bits_q != 4'd0) begin
              tx_bits_d  = tx_bits_q - 4'd1;
              line_tx_d  = sh_cur[0];
              tx_shift_d = {1'b0, sh_cur[7:1]};
            end else if (tx_extra_q[1]) begin
              tx_extra_d = tx_extra_q - 2'd1;
              line_tx_d  = pv_cur;
            end else if (tx_extra_q != 2'd0) begin
              tx_extra_d = tx_extra_q - 2'd1;
              line_tx_d  = 1'b1;
            end else begin
              line_tx_d = 1'b1;
              if (tx_cnt_q != '0) begin
                txb = 1'b1;
              end else begin
                tx_prog_d = 1'b0;
                tx_treq_d = 1'b0;
                arm       = 1'b1;
              end
            end
          end else if (fire) begin
            rx_bits_d = rbits;
            if (rbits != 4'd0) begin
              rx_shift_d = {rx_pin_i, rx_shift_q[7:1]};
              if (rbits == 4'd1) begin
                rts_d = 1'b1;
              end
            end else if (rx_extra_q != 2'd0) begin
              rx_extra_d = rx_extra_q - 2'd1;
              err_par_d  = rx_pin_i;
            end else begin
              if (!rx_pin_i) begin
                err_frame_d = 1'b1;
                err_par_d   = 1'b0;
              end else begin
                err_frame_d = 1'b0;
                err_par_d   = par_en_q && (err_par_q != parity_of(rx_byte, n7, odd_q));
                if (!err_par_d && (rx_cnt_q != CntW'(FifoDepth))) begin
                  rx_we     = 1'b1;
                  rx_tail_d = ptr_inc(rx_tail_q);
                  rx_cnt_d  = rx_cnt_q + 1'b1;
                end
              end
              rx_shift_d = 8'h00;
              rx_prog_d  = 1'b0;
              armed_d    = 1'b0;
              if (!tx_treq_q) begin
                if (rx_cnt_d != CntW'(FifoDepth)) begin
                  arm = 1'b1;
                end
              end else if (tx_cnt_q != '0) begin
                txb = 1'b1;
              end
            end
          end
        end else if (armed_q && !rx_pin_i) begin
          rx_prog_d   = 1'b1;
          err_frame_d = 1'b0;
          err_par_d   = 1'b0;
          rx_shift_d  = 8'h00;
          rx_bits_d   = nb + 4'd1;
          rx_extra_d  = {1'b0, par_en_q};
          tick_d      = {1'b0, tpb_q} + {2'b00, tpb_q[15:1]};
        end
      end
      OpPush: begin
        if (tx_cnt_q != CntW'(FifoDepth)) begin
          tx_we     = 1'b1;
          tx_tail_d = ptr_inc(tx_tail_q);
          tx_cnt_d  = tx_cnt_q + 1'b1;
          tx_treq_d = 1'b1;
          if (!tx_prog_q) begin
            rts_d = 1'b1;
            if (!rx_prog_q) begin
              armed_d = 1'b0;
              txb     = 1'b1;
            end
          end
        end
      end
      OpPop: begin
        if (!(armed_q || rx_prog_q || tx_treq_q)) begin
          arm = 1'b1;
        end
        if (rx_cnt_q != '0) begin
          rx_re      = 1'b1;
          rx_head_d  = ptr_inc(rx_head_q);
          rx_cnt_d   = rx_cnt_q - 1'b1;
          rx_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (arm) begin
      armed_d    = 1'b1;
      rts_d      = 1'b0;
      rx_shift_d = 8'h00;
    end

    // The new byte arrives from the registered RAM read port; a byte written in
    // the same cycle to the entry being read is forwarded instead.
    if (txb) begin
      tx_re         = 1'b1;
      tx_head_d     = ptr_inc(tx_head_q);
      tx_cnt_d      = tx_cnt_d - 1'b1;
      tx_bits_d     = nb;
      tx_extra_d    = par_en_q ? 2'd2 : 2'd1;
      tx_pend_d     = 1'b1;
      tx_pn7_d      = n7;
      tx_podd_d     = odd_q;
      tx_fwd_d      = tx_we && (tx_tail_q == tx_head_q);
      tx_fwd_byte_d = tx_byte_i;
      tx_prog_d     = 1'b1;
      line_tx_d     = 1'b0;
      tick_d        = {1'b0, tpb_q};
    end
  end

  assign tx_ram_o = '{we: tx_we & step_en_i, waddr: tx_tail_q, wdata: tx_byte_i,
                      re: tx_re & step_en_i, raddr: tx_head_q};
  assign rx_ram_o = '{we: rx_we & step_en_i, waddr: rx_tail_q, wdata: rx_byte,
                      re: rx_re & step_en_i, raddr: rx_head_q};

  assign status_o = '{tx_line: line_tx_q, rts_line: rts_q, rx_valid: rx_valid_q,
                      tx_busy: tx_prog_q, rx_busy: rx_prog_q,
                      tx_full: (tx_cnt_q == CntW'(FifoDepth)),
                      frame_error: err_frame_q, parity_error: err_par_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_bits_q <= 4'd8;  par_en_q <= 1'b0;  odd_q <= 1'b0;  tpb_q <= 16'd104;
      tx_head_q <= '0;  tx_tail_q <= '0;  tx_cnt_q <= '0;
      rx_head_q <= '0;  rx_tail_q <= '0;  rx_cnt_q <= '0;
      tx_shift_q <= 8'h00;  tx_bits_q <= 4'd0;  tx_extra_q <= 2'd0;  par_val_q <= 1'b0;
      tx_pend_q <= 1'b0;  tx_pn7_q <= 1'b0;  tx_podd_q <= 1'b0;
      tx_fwd_q <= 1'b0;  tx_fwd_byte_q <= 8'h00;
      rx_shift_q <= 8'h00;  rx_bits_q <= 4'd0;  rx_extra_q <= 2'd0;
      tick_q <= '0;
      tx_prog_q <= 1'b0;  tx_treq_q <= 1'b0;  rx_prog_q <= 1'b0;  armed_q <= 1'b1;
      err_frame_q <= 1'b0;  err_par_q <= 1'b0;
      line_tx_q <= 1'b1;  rts_q <= 1'b0;  rx_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgDataBits:    data_bits_q <= cfg_wdata_i[3:0];
          CfgParityEn:    par_en_q    <= cfg_wdata_i[0];
          CfgOddParity:   odd_q       <= cfg_wdata_i[0];
          CfgTicksPerBit: tpb_q       <= cfg_wdata_i[15:0];
          default: begin
          end
        endcase
      end
      if (step_en_i) begin
        tx_head_q <= tx_head_d;  tx_tail_q <= tx_tail_d;  tx_cnt_q <= tx_cnt_d;
        rx_head_q <= rx_head_d;  rx_tail_q <= rx_tail_d;  rx_cnt_q <= rx_cnt_d;
        tx_shift_q <= tx_shift_d;  tx_bits_q <= tx_bits_d;  tx_extra_q <= tx_extra_d;
        par_val_q <= par_val_d;  tx_pend_q <= tx_pend_d;
        tx_pn7_q <= tx_pn7_d;  tx_podd_q <= tx_podd_d;
        tx_fwd_q <= tx_fwd_d;  tx_fwd_byte_q <= tx_fwd_byte_d;
        rx_shift_q <= rx_shift_d;  rx_bits_q <= rx_bits_d;  rx_extra_q <= rx_extra_d;
        tick_q <= tick_d;
        tx_prog_q <= tx_prog_d;  tx_treq_q <= tx_treq_d;
        rx_prog_q <= rx_prog_d;  armed_q <= armed_d;
        err_frame_q <= err_frame_d;  err_par_q <= err_par_d;
        line_tx_q <= line_tx_d;  rts_q <= rts_d;  rx_valid_q <= rx_valid_d;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/half_duplex_uart_with_fifos.sv
// ----------------------------------------------------------------------------
// Half-duplex UART with transmit and receive FIFOs
//
//   Channel   Direction  Handshake                    Payload
//   input     in         in_valid_i / in_ready_o      opcode_i, tx_byte_i, rx_pin_i
//   output    out        out_valid_o / out_ready_i    line, FIFO and error status
//   config    in         cfg_we_i (no wait)           cfg_index_i, cfg_wdata_i
//
// One word is taken per clock cycle; each word is a single read-modify-write
// of the control state and at most one write and one read of each FIFO RAM.
// The RAM read port is registered, so a dequeued transmit byte reaches the
// shift path through its read data register, with same-entry forwarding.
// The FIFO RAMs need no clearing after reset; the block is ready at once.
// A new word is taken whenever the output register is empty or being drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module half_duplex_uart_with_fifos (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire logic [1:0]                     opcode_i,
  input  wire logic [7:0]                     tx_byte_i,
  input  wire logic                           rx_pin_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output      logic                           tx_line_o,
  output      logic                           rts_line_o,
  output      logic [7:0]                     rx_data_o,
  output      logic                           rx_valid_o,
  output      logic                           tx_busy_o,
  output      logic                           rx_busy_o,
  output      logic                           tx_full_o,
  output      logic                           frame_error_o,
  output      logic                           parity_error_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [hduart_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [hduart_pkg::CfgW-1:0]    cfg_wdata_i
);

  import hduart_pkg::*;

  logic     step_en;
  logic     out_valid_q;
  ram_req_t tx_ram, rx_ram;
  logic [7:0] tx_rdata, rx_rdata;
  status_t  status;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step_en    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  hduart_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (step_en),
    .op_i        (opcode_i),
    .tx_byte_i   (tx_byte_i),
    .rx_pin_i    (rx_pin_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tx_ram_o    (tx_ram),
    .rx_ram_o    (rx_ram),
    .tx_rdata_i  (tx_rdata),
    .status_o    (status)
  );

  hduart_ram #(.Depth(FifoDepth), .Width(8)) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_ram.we),
    .waddr_i (tx_ram.waddr),
    .wdata_i (tx_ram.wdata),
    .re_i    (tx_ram.re),
    .raddr_i (tx_ram.raddr),
    .rdata_o (tx_rdata)
  );

  hduart_ram #(.Depth(FifoDepth), .Width(8)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_ram.we),
    .waddr_i (rx_ram.waddr),
    .wdata_i (rx_ram.wdata),
    .re_i    (rx_ram.re),
    .raddr_i (rx_ram.raddr),
    .rdata_o (rx_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign tx_line_o      = status.tx_line;
  assign rts_line_o     = status.rts_line;
  assign rx_valid_o     = status.rx_valid;
  assign rx_data_o      = status.rx_valid ? rx_rdata : 8'h00;
  assign tx_busy_o      = status.tx_busy;
  assign rx_busy_o      = status.rx_busy;
  assign tx_full_o      = status.tx_full;
  assign frame_error_o  = status.frame_error;
  assign parity_error_o = status.parity_error;

endmodule

`default_nettype wire

### rtl/hduart_checker.sv
// ----------------------------------------------------------------------------
// Half-duplex UART port checker
// Properties on the top-level ports, attached to the top level by a bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "half_duplex_uart_with_fifos_defines.svh"

module hduart_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] rx_data_o,
  input wire logic       rx_valid_o,
  input wire logic       tx_line_o,
  input wire logic       rts_line_o,
  input wire logic       tx_busy_o,
  input wire logic       frame_error_o,
  input wire logic       parity_error_o
);

  // With no popped byte the data word reads as zero.
  `HDU_ASSERT_SAME(a_rx_data_zero, out_valid_o && !rx_valid_o, rx_data_o == 8'h00)

  // The transmit line idles high whenever no frame is being sent.
  `HDU_ASSERT_SAME(a_tx_idle_high, !tx_busy_o, tx_line_o)

  // While transmitting, the far end is always told not to send.
  `HDU_ASSERT_SAME(a_rts_during_tx, tx_busy_o, rts_line_o)

  // A framing error never reports a parity error at the same time.
  `HDU_ASSERT_SAME(a_err_exclusive, frame_error_o, !parity_error_o)

  // A stalled result word keeps its popped data.
  `HDU_ASSERT_NEXT(a_stall_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(rx_data_o))

endmodule

bind half_duplex_uart_with_fifos hduart_checker u_hduart_checker (.*);

`default_nettype wire
